// File: hw/rtl/bdzp_pkg.sv
// ----------------------------------------------------------------------------
// bdzp_pkg
// Types and constants shared by the busbar dead-zone protection block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdzp_pkg;

   // Register map, index = paddr[3:2]
   typedef enum logic [1:0] {
      REG_OPEN_CURRENT_LIMIT  = 2'd0,
      REG_CLOSE_CURRENT_LIMIT = 2'd1,
      REG_OPEN_DELAY_MS       = 2'd2,
      REG_CLOSE_DELAY_MS      = 2'd3
   } reg_index_type;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned NUM_BRK    = 4;
   localparam int unsigned NUM_TIE    = 2;

   // Register reset values, rated/1000 and ms
   localparam logic [15:0] OPEN_CURRENT_LIMIT_RST  = 16'd40;
   localparam logic [15:0] CLOSE_CURRENT_LIMIT_RST = 16'd100;
   localparam logic [15:0] OPEN_DELAY_MS_RST       = 16'd400;
   localparam logic [15:0] CLOSE_DELAY_MS_RST      = 16'd150;

   // Both connected buses running
   localparam logic [1:0] BUS_RUN_BOTH = 2'b11;

   typedef struct packed {
      logic [1:0]  brk_index;
      logic [2:0]  pole_closed;
      logic [15:0] current_a;
      logic [15:0] current_b;
      logic [15:0] current_c;
      logic        in_diff;
      logic        indep_op;
      logic        manual_close;
      logic [1:0]  bus_run;
      logic [2:0]  diff_trip;
      logic        brk_trip;
      logic [31:0] now_time;
   } req_type;

   typedef struct packed {
      logic [1:0] out_index;
      logic       open_operate;
      logic       close_operate;
      logic       dead_zone_latched;
   } rsp_type;

   // Stored state of one relay timer
   typedef struct packed {
      logic        running;
      logic [31:0] start;
   } timer_type;

   // Evaluation controls for one relay timer
   typedef struct packed {
      logic active;   // relay evaluated at all this item
      logic cond;     // timing condition holds
      logic enables;  // operate permitted on expiry
   } relay_ctl_type;

endpackage

`default_nettype wire

// File: hw/rtl/bdzp_relay_timer.sv
// ----------------------------------------------------------------------------
// bdzp_relay_timer
// Next-state and operate logic of one dead-zone relay delay timer.
// ----------------------------------------------------------------------------
`default_nettype none

module bdzp_relay_timer (
   input  bdzp_pkg::timer_type     cur,
   input  bdzp_pkg::relay_ctl_type ctl,
   input  logic [31:0]             now_time,
   input  logic [15:0]             delay_ms,
   output bdzp_pkg::timer_type     nxt,
   output logic                    operate
);
   import bdzp_pkg::*;

   logic [31:0] start_eff;
   logic [31:0] elapsed;
   logic        expired;

   // Start the timer at the current time when it is idle
   assign start_eff = cur.running ? cur.start : now_time;
   assign elapsed   = now_time - start_eff;
   assign expired   = elapsed >= {16'd0, delay_ms};

   // Hold when inactive, stop when condition fails, stop on operate
   always_comb begin
      nxt     = cur;
      operate = 1'b0;
      if (ctl.active) begin
         if (!ctl.cond) begin
            nxt.running = 1'b0;
         end else begin
            operate     = expired && ctl.enables;
            nxt.start   = start_eff;
            nxt.running = !(expired && ctl.enables);
         end
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/busbar_dead_zone_protection.sv
// ----------------------------------------------------------------------------
// busbar_dead_zone_protection
// Open and tie-close dead-zone relays with sticky per-breaker latches.
// ----------------------------------------------------------------------------
// The result is registered: it becomes valid in the cycle after the item is accepted.
// Throughput: one item per cycle while results are taken; the single result
//   register is refilled in the cycle it is taken, and timer state updates at each accept.
// Reset: synchronous, active high; clears timers, latches and the result valid
//   flag, and loads the registers with their default limits and delays.
`default_nettype none

module busbar_dead_zone_protection (
   input  logic                          clock,
   input  logic                          reset,
   // Evaluation request
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bdzp_pkg::req_type             req_data,
   // Evaluation result
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bdzp_pkg::rsp_type             rsp_data,
   // Register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bdzp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import bdzp_pkg::*;

   logic [15:0] open_limit_ff;
   logic [15:0] close_limit_ff;
   logic [15:0] open_delay_ff;
   logic [15:0] close_delay_ff;

   timer_type   open_tmr_ff  [NUM_BRK];
   timer_type   close_tmr_ff [NUM_TIE];
   logic [NUM_BRK-1:0] latch_ff;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   logic          accept;
   logic          is_tie;
   logic          brk_open;
   logic          above_open;
   logic          above_close;
   logic          trips_ok;
   relay_ctl_type open_ctl;
   relay_ctl_type close_ctl;
   timer_type     open_cur, open_nxt;
   timer_type     close_cur, close_nxt;
   logic          open_op, close_op;
   logic          csr_wr;
   reg_index_type csr_idx;

   // Register access
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = reg_index_type'(paddr[3:2]);

   always_comb begin
      unique case (csr_idx)
         REG_OPEN_CURRENT_LIMIT:  prdata = {16'd0, open_limit_ff};
         REG_CLOSE_CURRENT_LIMIT: prdata = {16'd0, close_limit_ff};
         REG_OPEN_DELAY_MS:       prdata = {16'd0, open_delay_ff};
         REG_CLOSE_DELAY_MS:      prdata = {16'd0, close_delay_ff};
         default:                 prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_limit_ff  <= OPEN_CURRENT_LIMIT_RST;
         close_limit_ff <= CLOSE_CURRENT_LIMIT_RST;
         open_delay_ff  <= OPEN_DELAY_MS_RST;
         close_delay_ff <= CLOSE_DELAY_MS_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_OPEN_CURRENT_LIMIT:  open_limit_ff  <= pwdata[15:0];
            REG_CLOSE_CURRENT_LIMIT: close_limit_ff <= pwdata[15:0];
            REG_OPEN_DELAY_MS:       open_delay_ff  <= pwdata[15:0];
            REG_CLOSE_DELAY_MS:      close_delay_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Accept while the result register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Decode the evaluation
   assign is_tie      = !req_data.brk_index[1];
   assign brk_open    = req_data.pole_closed == 3'd0;
   assign above_open  = (req_data.current_a > open_limit_ff) ||
                        (req_data.current_b > open_limit_ff) ||
                        (req_data.current_c > open_limit_ff);
   assign above_close = (req_data.current_a > close_limit_ff) ||
                        (req_data.current_b > close_limit_ff) ||
                        (req_data.current_c > close_limit_ff);
   assign trips_ok    = req_data.diff_trip[0] && (req_data.diff_trip[2:1] != 2'b00) &&
                        req_data.brk_trip;

   always_comb begin
      open_ctl.active  = req_data.in_diff;
      if (is_tie) begin
         open_ctl.cond    = (req_data.bus_run == BUS_RUN_BOTH) && !above_open;
         open_ctl.enables = brk_open && req_data.indep_op;
      end else begin
         open_ctl.cond    = !above_open;
         open_ctl.enables = !req_data.manual_close && brk_open && req_data.indep_op;
      end
      close_ctl.active  = is_tie && !latch_ff[req_data.brk_index];
      close_ctl.cond    = brk_open && above_close && trips_ok;
      close_ctl.enables = 1'b1;
   end

   assign open_cur  = open_tmr_ff[req_data.brk_index];
   assign close_cur = close_tmr_ff[req_data.brk_index[0]];

   bdzp_relay_timer u_open_timer (
      .cur      (open_cur),
      .ctl      (open_ctl),
      .now_time (req_data.now_time),
      .delay_ms (open_delay_ff),
      .nxt      (open_nxt),
      .operate  (open_op)
   );

   bdzp_relay_timer u_close_timer (
      .cur      (close_cur),
      .ctl      (close_ctl),
      .now_time (req_data.now_time),
      .delay_ms (close_delay_ff),
      .nxt      (close_nxt),
      .operate  (close_op)
   );

   // Form the result
   always_comb begin
      rsp_in.out_index         = req_data.brk_index;
      rsp_in.open_operate      = open_op;
      rsp_in.close_operate     = close_op;
      rsp_in.dead_zone_latched = latch_ff[req_data.brk_index] || open_op || close_op;
   end

   // Advance timer and latch state on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BRK; i++) begin
            open_tmr_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_TIE; i++) begin
            close_tmr_ff[i] <= '0;
         end
         latch_ff <= '0;
      end else if (accept) begin
         open_tmr_ff[req_data.brk_index] <= open_nxt;
         if (is_tie) begin
            close_tmr_ff[req_data.brk_index[0]] <= close_nxt;
         end
         if (open_op || close_op) begin
            latch_ff[req_data.brk_index] <= 1'b1;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bdzp_checker.sv
// ----------------------------------------------------------------------------
// bdzp_checker
// Port-level checks of the busbar dead-zone protection block.
// ----------------------------------------------------------------------------
`default_nettype none

module bdzp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bdzp_pkg::rsp_type rsp_data
);
   import bdzp_pkg::*;

   // A stalled result stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result changed while stalled");

   // An empty result register never blocks the request side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   // Section breakers have no close relay
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_index[1] |-> !rsp_data.close_operate)
      else $error("close relay operated on a section breaker");

   // Any operate sets the latch in the same result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.open_operate || rsp_data.close_operate)
         |-> rsp_data.dead_zone_latched)
      else $error("operate without latch");

endmodule

bind busbar_dead_zone_protection bdzp_checker u_bdzp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
